// File: src/aabb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pkg
// shared types and constants of the all-pairs box contact engine
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int MaxSlots = 32;
  localparam int FracBits = 4;
  localparam int SlotW    = 5;
  localparam int CntW     = 6;
  localparam int EdgeW    = 22;
  localparam int RangeW   = 16;
  localparam int CfgW     = 16;

  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_RUN  = 1'b1;

  localparam logic CFG_ACTIVE_COUNT  = 1'b0;
  localparam logic CFG_CONTACT_RANGE = 1'b1;

  localparam logic [RangeW-1:0] RangeReset = RangeW'(10 << FracBits);

  typedef logic signed [EdgeW-1:0] edge_t;

  // the edges of one box: left, right, top and bottom
  typedef struct packed {
    edge_t lft;
    edge_t rgt;
    edge_t top;
    edge_t bot;
  } box_t;

  // controller to datapath
  typedef struct packed {
    logic             clear;
    logic             load_a;
    logic             pair;
    logic [SlotW-1:0] i_idx;
    logic [SlotW-1:0] j_idx;
    logic             emit;
    logic [SlotW-1:0] e_idx;
    logic             e_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

// File: src/aabb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_ctrl
// run sequencer: walks all pairs i<j, then emits one result per slot
// ----------------------------------------------------------------------------
module aabb_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     run_start,
  input  logic [aabb_pkg::CntW-1:0] n_in,
  input  aabb_pkg::dp_sts_t        sts,
  output aabb_pkg::dp_cmd_t        cmd,
  output logic                     idle
);

  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_LOADA, S_PAIR, S_DRAIN, S_EMIT} state_t;

  state_t                      state_r;
  logic [aabb_pkg::CntW-1:0]   n_r;
  logic [aabb_pkg::CntW-1:0]   i_r;
  logic [aabb_pkg::CntW-1:0]   j_r;
  logic [1:0]                  drain_r;

  assign idle = (state_r == S_IDLE);

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.i_idx  = i_r[aabb_pkg::SlotW-1:0];
    cmd.j_idx  = j_r[aabb_pkg::SlotW-1:0];
    cmd.e_idx  = i_r[aabb_pkg::SlotW-1:0];
    cmd.e_last = (i_r + 1'b1 == n_r);
    unique case (state_r)
      S_CLEAR: cmd.clear  = 1'b1;
      S_LOADA: cmd.load_a = 1'b1;
      S_PAIR:  cmd.pair   = 1'b1;
      S_EMIT:  cmd.emit   = !sts.out_busy;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      drain_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (run_start) begin
            n_r     <= (n_in > aabb_pkg::CntW'(aabb_pkg::MaxSlots)) ?
                       aabb_pkg::CntW'(aabb_pkg::MaxSlots) : n_in;
            i_r     <= '0;
            state_r <= (n_in == '0) ? S_IDLE : S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (n_r == aabb_pkg::CntW'(1)) begin
            state_r <= S_DRAIN;
            drain_r <= '0;
          end else begin
            state_r <= S_LOADA;
          end
        end
        S_LOADA: begin
          j_r     <= i_r + 1'b1;
          state_r <= S_PAIR;
        end
        S_PAIR: begin
          if (j_r + 1'b1 == n_r) begin
            if (i_r + 2'd2 == n_r) begin
              state_r <= S_DRAIN;
              drain_r <= '0;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_LOADA;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_DRAIN: begin
          // let the pair pipeline settle
          drain_r <= drain_r + 1'b1;
          if (drain_r == 2'd3) begin
            i_r     <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!sts.out_busy) begin
            if (i_r + 1'b1 == n_r) state_r <= S_IDLE;
            i_r <= i_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ap_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (state_r == S_EMIT) && (i_r < n_r))
    else $error("emit outside result phase");
  ap_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pair |-> (i_r < j_r) && (j_r < n_r))
    else $error("bad pair indices");
  ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> !(state_r == S_IDLE && $past(state_r) == S_CLEAR))
    else $error("run left from clear");

endmodule

// File: src/aabb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_dp
// box store, pair overlap and side test pipeline, result registers
// ----------------------------------------------------------------------------
module aabb_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ld_en,
  input  logic [aabb_pkg::SlotW-1:0]      ld_slot,
  input  aabb_pkg::box_t                  ld_box,
  input  logic                            ld_present,
  input  logic                            ld_solid,
  input  logic [aabb_pkg::RangeW-1:0]     range,
  input  aabb_pkg::dp_cmd_t               cmd,
  output aabb_pkg::dp_sts_t               sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [aabb_pkg::SlotW-1:0]      out_slot,
  output logic                            out_collided,
  output logic [31:0]                     out_partners,
  output logic                            out_hit_right,
  output logic                            out_hit_left,
  output logic                            out_hit_down,
  output logic                            out_hit_up,
  output logic                            out_last
);

  localparam int N = aabb_pkg::MaxSlots;

  // box memory, edges precomputed at load
  aabb_pkg::box_t            box_mem [N];
  logic [N-1:0]              present_r;
  logic [N-1:0]              solid_r;
  logic [N-1:0]              contact_r [N];
  logic [3:0]                side_r [N];

  aabb_pkg::box_t            a_r;
  logic                      a_pr_r, a_so_r;
  aabb_pkg::box_t            b_r;
  logic                      p1_v_r;
  logic [aabb_pkg::SlotW-1:0] p1_i_r, p1_j_r;
  logic                      p1_ok_r;

  logic                      ov;
  logic [3:0]                cls_a, cls_b;
  logic signed [aabb_pkg::EdgeW:0] rng;

  assign rng = {1'b0, $signed({{(aabb_pkg::EdgeW-aabb_pkg::RangeW){1'b0}}, range})};

  function automatic logic [3:0] classify(aabb_pkg::box_t t, aabb_pkg::box_t o,
                                          logic signed [aabb_pkg::EdgeW:0] r);
    logic signed [aabb_pkg::EdgeW:0] tl, tr, tb, ol, orr, ot;
    tl = t.lft; tr = t.rgt; tb = t.bot; ol = o.lft; orr = o.rgt; ot = o.top;
    priority if (tr >= ol && tr <= ol + r) classify = 4'b0001;
    else if (tl <= orr && tl + r >= orr)   classify = 4'b0010;
    else if (tb >= ot && tb <= ot + r)     classify = 4'b0100;
    else                                   classify = 4'b1000;
  endfunction

  // store writes and flags
  always_ff @(posedge clk) begin
    if (ld_en) box_mem[ld_slot] <= ld_box;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      solid_r   <= '0;
    end else if (ld_en) begin
      present_r[ld_slot] <= ld_present;
      solid_r[ld_slot]   <= ld_solid;
    end
  end

  // stage 0: registered memory reads
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_r    <= box_mem[cmd.i_idx];
      a_pr_r <= present_r[cmd.i_idx];
      a_so_r <= solid_r[cmd.i_idx];
    end
    b_r    <= box_mem[cmd.j_idx];
    p1_i_r <= cmd.i_idx;
    p1_j_r <= cmd.j_idx;
    p1_ok_r <= present_r[cmd.j_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else        p1_v_r <= cmd.pair;
  end

  // stage 1: overlap and side classification
  assign ov = p1_v_r && a_pr_r && p1_ok_r &&
              (b_r.rgt >= a_r.lft) && (b_r.lft <= a_r.rgt) &&
              (b_r.bot >= a_r.top) && (b_r.top <= a_r.bot);
  assign cls_a = classify(a_r, b_r, rng);
  assign cls_b = classify(b_r, a_r, rng);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int k = 0; k < N; k++) begin
        contact_r[k] <= '0;
        side_r[k]    <= '0;
      end
    end else if (ov) begin
      contact_r[p1_i_r][p1_j_r] <= 1'b1;
      contact_r[p1_j_r][p1_i_r] <= 1'b1;
      if (solid_r[p1_i_r] && solid_r[p1_j_r] && a_so_r) begin
        side_r[p1_i_r] <= side_r[p1_i_r] | cls_a;
        side_r[p1_j_r] <= side_r[p1_j_r] | cls_b;
      end
    end
  end

  // result register
  assign sts.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot      <= cmd.e_idx;
      out_partners  <= 32'(contact_r[cmd.e_idx]);
      out_collided  <= |contact_r[cmd.e_idx];
      out_hit_right <= side_r[cmd.e_idx][0];
      out_hit_left  <= side_r[cmd.e_idx][1];
      out_hit_down  <= side_r[cmd.e_idx][2];
      out_hit_up    <= side_r[cmd.e_idx][3];
      out_last      <= cmd.e_last;
    end
  end

  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
  ap_ov_present: assert property (@(posedge clk) disable iff (!rst_n)
    ov |-> present_r[p1_i_r] && present_r[p1_j_r])
    else $error("overlap on absent slot");
  ap_sym: assert property (@(posedge clk) disable iff (!rst_n)
    ov |=> contact_r[$past(p1_i_r)][$past(p1_j_r)])
    else $error("contact bit not set");

endmodule

// File: src/aabb_all_pairs_contact_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_all_pairs_contact_engine
// all-pairs box overlap with solid side classification
// ----------------------------------------------------------------------------
// load: writes one slot, no result
// run over n slots: clear, all n(n-1)/2 pairs i<j row by row after loading
//   box i, drain, then n results at one per cycle while not stalled
// rate is set by the single shared pair test unit, one pair a cycle in a row
// reset: synchronous active low; clears present flags, active_count to 0,
//   contact_range to ten pixels; box entries are undefined until loaded
module aabb_all_pairs_contact_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [0:0]          in_opcode,
  input  logic [4:0]          in_slot,
  input  logic signed [19:0]  in_pos_x,
  input  logic signed [19:0]  in_pos_y,
  input  logic [15:0]         in_size_w,
  input  logic [15:0]         in_size_h,
  input  logic signed [15:0]  in_left_offset,
  input  logic signed [15:0]  in_right_offset,
  input  logic signed [15:0]  in_top_offset,
  input  logic signed [15:0]  in_bottom_offset,
  input  logic                in_present,
  input  logic                in_solid,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [4:0]          out_out_slot,
  output logic                out_collided,
  output logic [31:0]         out_partners,
  output logic                out_hit_right,
  output logic                out_hit_left,
  output logic                out_hit_down,
  output logic                out_hit_up,
  output logic                out_last
);

  logic [aabb_pkg::CntW-1:0]   active_count_r;
  logic [aabb_pkg::RangeW-1:0] contact_range_r;
  logic                        idle, in_xfer;
  aabb_pkg::dp_cmd_t           cmd;
  aabb_pkg::dp_sts_t           sts;
  aabb_pkg::box_t              ld_box;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r  <= '0;
      contact_range_r <= aabb_pkg::RangeReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aabb_pkg::CFG_ACTIVE_COUNT:  active_count_r  <= cfg_wdata[aabb_pkg::CntW-1:0];
        aabb_pkg::CFG_CONTACT_RANGE: contact_range_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = !idle || out_valid;
  assign in_xfer  = in_valid && !in_stall;

  // edges formed at load
  always_comb begin
    ld_box.lft = aabb_pkg::edge_t'(in_pos_x) + aabb_pkg::edge_t'(in_left_offset);
    ld_box.rgt = aabb_pkg::edge_t'(in_pos_x) + aabb_pkg::edge_t'({1'b0, in_size_w})
                 + aabb_pkg::edge_t'(in_right_offset);
    ld_box.top = aabb_pkg::edge_t'(in_pos_y) + aabb_pkg::edge_t'(in_top_offset);
    ld_box.bot = aabb_pkg::edge_t'(in_pos_y) + aabb_pkg::edge_t'({1'b0, in_size_h})
                 + aabb_pkg::edge_t'(in_bottom_offset);
  end

  aabb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_start (in_xfer && in_opcode == aabb_pkg::OP_RUN),
    .n_in      (active_count_r),
    .sts       (sts),
    .cmd       (cmd),
    .idle      (idle)
  );

  aabb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld_en         (in_xfer && in_opcode == aabb_pkg::OP_LOAD),
    .ld_slot       (in_slot),
    .ld_box        (ld_box),
    .ld_present    (in_present),
    .ld_solid      (in_solid),
    .range         (contact_range_r),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_slot      (out_out_slot),
    .out_collided  (out_collided),
    .out_partners  (out_partners),
    .out_hit_right (out_hit_right),
    .out_hit_left  (out_hit_left),
    .out_hit_down  (out_hit_down),
    .out_hit_up    (out_hit_up),
    .out_last      (out_last)
  );

endmodule

// File: tb/sv/aabb_contact_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_contact_checker
// watches the load/run and result channels, predicts each run's per-slot
// contact report and compares every result transfer field by field
// ----------------------------------------------------------------------------
module aabb_contact_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [0:0]         in_opcode,
  input  logic [4:0]         in_slot,
  input  logic signed [19:0] in_pos_x,
  input  logic signed [19:0] in_pos_y,
  input  logic [15:0]        in_size_w,
  input  logic [15:0]        in_size_h,
  input  logic signed [15:0] in_left_offset,
  input  logic signed [15:0] in_right_offset,
  input  logic signed [15:0] in_top_offset,
  input  logic signed [15:0] in_bottom_offset,
  input  logic               in_present,
  input  logic               in_solid,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [4:0]         out_out_slot,
  input  logic               out_collided,
  input  logic [31:0]        out_partners,
  input  logic               out_hit_right,
  input  logic               out_hit_left,
  input  logic               out_hit_down,
  input  logic               out_hit_up,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending,
  output int                 report_count
);

  typedef struct packed {
    logic [4:0]  slot;
    logic        collided;
    logic [31:0] partners;
    logic        rgt, lft, dwn, up;
    logic        last;
  } report_t;

  typedef logic signed [31:0] coord_t;

  // shadow copy of the slot table and registers
  coord_t     box_l [aabb_pkg::MaxSlots];
  coord_t     box_r [aabb_pkg::MaxSlots];
  coord_t     box_t [aabb_pkg::MaxSlots];
  coord_t     box_b [aabb_pkg::MaxSlots];
  logic       is_present [aabb_pkg::MaxSlots];
  logic       solid_flag [aabb_pkg::MaxSlots];
  logic [5:0] n_active;
  logic [15:0] range_q4;

  report_t report_q[$];

  assign pending = report_q.size();

  // side priority: right, left, down, else up; returns {up,down,left,right}
  function automatic logic [3:0] side_of(int t, int o, coord_t r);
    if (box_r[t] >= box_l[o] && box_r[t] <= box_l[o] + r) return 4'b0001;
    if (box_l[t] <= box_r[o] && box_l[t] + r >= box_r[o]) return 4'b0010;
    if (box_b[t] >= box_t[o] && box_b[t] <= box_t[o] + r) return 4'b0100;
    return 4'b1000;
  endfunction

  task automatic predict_run();
    logic [31:0] touch [aabb_pkg::MaxSlots];
    logic [3:0]  sides [aabb_pkg::MaxSlots];
    int n;
    report_t rep;
    n = (n_active > 32) ? 32 : n_active;
    for (int i = 0; i < aabb_pkg::MaxSlots; i++) begin
      touch[i] = '0;
      sides[i] = '0;
    end
    for (int i = 0; i < n; i++) begin
      if (!is_present[i]) continue;
      for (int j = i + 1; j < n; j++) begin
        if (!is_present[j]) continue;
        if (box_r[j] >= box_l[i] && box_l[j] <= box_r[i] &&
            box_b[j] >= box_t[i] && box_t[j] <= box_b[i]) begin
          touch[i][j] = 1'b1;
          touch[j][i] = 1'b1;
          if (solid_flag[i] && solid_flag[j]) begin
            sides[i] |= side_of(i, j, coord_t'(range_q4));
            sides[j] |= side_of(j, i, coord_t'(range_q4));
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      rep.slot     = 5'(i);
      rep.partners = touch[i];
      rep.collided = |touch[i];
      rep.rgt      = sides[i][0];
      rep.lft      = sides[i][1];
      rep.dwn      = sides[i][2];
      rep.up       = sides[i][3];
      rep.last     = (i == n - 1);
      report_q.push_back(rep);
    end
  endtask

  always @(posedge clk) begin
    report_t exp_r;
    if (!rst_n) begin
      n_active <= '0;
      range_q4 <= aabb_pkg::RangeReset;
      for (int i = 0; i < aabb_pkg::MaxSlots; i++) begin
        is_present[i] <= 1'b0;
        solid_flag[i] <= 1'b0;
      end
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == aabb_pkg::CFG_ACTIVE_COUNT) n_active <= cfg_wdata[5:0];
        else range_q4 <= cfg_wdata;
      end
      // input transfer
      if (in_valid && !in_stall) begin
        if (in_opcode == aabb_pkg::OP_LOAD) begin
          box_l[in_slot] <= coord_t'(in_pos_x) + coord_t'(in_left_offset);
          box_r[in_slot] <= coord_t'(in_pos_x) + coord_t'({16'd0, in_size_w})
                            + coord_t'(in_right_offset);
          box_t[in_slot] <= coord_t'(in_pos_y) + coord_t'(in_top_offset);
          box_b[in_slot] <= coord_t'(in_pos_y) + coord_t'({16'd0, in_size_h})
                            + coord_t'(in_bottom_offset);
          is_present[in_slot] <= in_present;
          solid_flag[in_slot] <= in_solid;
        end else begin
          predict_run();
        end
      end
      // result transfer
      if (out_valid && !out_stall) begin
        report_count <= report_count + 1;
        if (report_q.size() == 0) begin
          $error("unexpected result for slot %0d", out_out_slot);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = report_q.pop_front();
          if ({out_out_slot, out_collided, out_partners, out_hit_right, out_hit_left,
               out_hit_down, out_hit_up, out_last} !== exp_r) begin
            fail_count <= fail_count + 1;
            if (out_out_slot !== exp_r.slot)
              $error("out_slot exp %0d got %0d", exp_r.slot, out_out_slot);
            if (out_collided !== exp_r.collided)
              $error("collided exp %0d got %0d", exp_r.collided, out_collided);
            if (out_partners !== exp_r.partners)
              $error("partners exp %h got %h", exp_r.partners, out_partners);
            if (out_hit_right !== exp_r.rgt)
              $error("hit_right exp %0d got %0d", exp_r.rgt, out_hit_right);
            if (out_hit_left !== exp_r.lft)
              $error("hit_left exp %0d got %0d", exp_r.lft, out_hit_left);
            if (out_hit_down !== exp_r.dwn)
              $error("hit_down exp %0d got %0d", exp_r.dwn, out_hit_down);
            if (out_hit_up !== exp_r.up)
              $error("hit_up exp %0d got %0d", exp_r.up, out_hit_up);
            if (out_last !== exp_r.last)
              $error("last exp %0d got %0d", exp_r.last, out_last);
          end
        end
      end
    end
  end

  initial begin
    fail_count   = 0;
    report_count = 0;
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives slot loads, collision runs and register settings into the contact
// engine with random gaps and result stalls; the checker scores the results
// ----------------------------------------------------------------------------
module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [0:0] in_opcode = aabb_pkg::OP_LOAD;
  logic [4:0] in_slot = '0;
  logic signed [19:0] in_pos_x = '0, in_pos_y = '0;
  logic [15:0] in_size_w = '0, in_size_h = '0;
  logic signed [15:0] in_left_offset = '0, in_right_offset = '0;
  logic signed [15:0] in_top_offset = '0, in_bottom_offset = '0;
  logic in_present = 1'b0, in_solid = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] out_out_slot;
  logic out_collided, out_hit_right, out_hit_left, out_hit_down, out_hit_up, out_last;
  logic [31:0] out_partners;
  int fail_count, pending, report_count;
  int item_count = 0;
  int run_count = 0;
  bit stall_on = 1'b1;

  always #2 clk = ~clk;

  aabb_all_pairs_contact_engine DUT (.*);

  aabb_contact_checker u_checker (.*);

  // random gap length, mostly short, a few long
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    if (!stall_on) out_stall <= 1'b0;
    else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 3) != 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one transfer on the input channel, then a random gap
  task automatic send_item(logic [0:0] op, logic [4:0] s, logic signed [19:0] px,
                           logic signed [19:0] py, logic [15:0] w, logic [15:0] h,
                           logic signed [15:0] lo, logic signed [15:0] ro,
                           logic signed [15:0] to, logic signed [15:0] bo,
                           logic pr, logic so);
    int g;
    in_valid <= 1'b1;
    in_opcode <= op; in_slot <= s; in_pos_x <= px; in_pos_y <= py;
    in_size_w <= w; in_size_h <= h; in_left_offset <= lo; in_right_offset <= ro;
    in_top_offset <= to; in_bottom_offset <= bo; in_present <= pr; in_solid <= so;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
    if (op == aabb_pkg::OP_RUN) run_count++;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_run();
    send_item(aabb_pkg::OP_RUN, 5'($urandom), 20'($urandom), 20'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // small box near the origin so that overlaps are frequent
  task automatic load_near(logic [4:0] s);
    send_item(aabb_pkg::OP_LOAD, s, 20'($signed($urandom_range(0, 1200)) - 600),
              20'($signed($urandom_range(0, 1200)) - 600),
              16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
              16'($signed($urandom_range(0, 120)) - 60),
              16'($signed($urandom_range(0, 120)) - 60),
              16'($signed($urandom_range(0, 120)) - 60),
              16'($signed($urandom_range(0, 120)) - 60),
              $urandom_range(0, 5) != 0, $urandom_range(0, 3) != 0);
  endtask

  // wait for every expected result plus the pipeline drain
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  initial begin
    logic [5:0] n;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // run with active count zero, and at reset values
    send_run();
    drain();
    write_reg(aabb_pkg::CFG_ACTIVE_COUNT, 16'd4);
    // slots 0..3: right and left contacts among slots 0..2, plus absent slot 3
    send_item(aabb_pkg::OP_LOAD, 0, 0, 0, 16'd160, 16'd160, 0, 0, 0, 0, 1, 1);
    send_item(aabb_pkg::OP_LOAD, 1, 20'sd150, 0, 16'd160, 16'd160, 0, 0, 0, 0, 1, 1);
    send_item(aabb_pkg::OP_LOAD, 2, 0, 20'sd150, 16'd160, 16'd160, 0, 0, 0, 0, 1, 1);
    send_item(aabb_pkg::OP_LOAD, 3, 20'sd100, 20'sd100, 16'd10, 16'd10, 0, 0, 0, 0, 0, 0);
    send_run();
    // edges touching exactly, and no contact window
    send_item(aabb_pkg::OP_LOAD, 3, 20'sd160, 20'sd160, 0, 0, 0, 0, 0, 0, 1, 1);
    drain();
    write_reg(aabb_pkg::CFG_CONTACT_RANGE, 16'd0);
    send_run();
    drain();
    write_reg(aabb_pkg::CFG_CONTACT_RANGE, 16'hFFFF);
    // field extremes on slots 31 and 30
    write_reg(aabb_pkg::CFG_ACTIVE_COUNT, 16'd32);
    for (int s = 4; s < 31; s++)
      send_item(aabb_pkg::OP_LOAD, 5'(s), 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
    send_item(aabb_pkg::OP_LOAD, 31, 20'sh80000, 20'sh80000, 16'hFFFF, 16'hFFFF,
              16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1, 1);
    send_item(aabb_pkg::OP_LOAD, 30, 20'sh7FFFF, 20'sh7FFFF, 16'hFFFF, 16'hFFFF,
              16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1, 0);
    send_run();
    drain();
    // count above the slot limit is clamped
    write_reg(aabb_pkg::CFG_ACTIVE_COUNT, 16'd63);
    send_run();
    drain();

    // random phases: a frame of loads then one or two runs, under varied settings
    while (item_count < 210) begin
      n = (($urandom_range(0, 5) == 0) ? 6'd32 : 6'($urandom_range(1, 10)));
      write_reg(aabb_pkg::CFG_ACTIVE_COUNT, 16'(n));
      write_reg(aabb_pkg::CFG_CONTACT_RANGE, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 300)));
      stall_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 7) == 0)
          send_item(aabb_pkg::OP_LOAD, 5'($urandom), 20'($urandom), 20'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        else
          load_near(5'($urandom_range(0, (n > 1) ? n - 1 : 1)));
      end
      send_run();
      if ($urandom_range(0, 2) == 0) send_run();
      drain();
    end
    stall_on = 1'b0;

    $display("covered %0d transfers in, %0d runs, %0d slot reports checked",
             item_count, run_count, report_count);
    if (fail_count == 0 && pending == 0)
      $display("[aabb_all_pairs_contact_engine] OK");
    else
      $display("[aabb_all_pairs_contact_engine] ERROR");
    $finish;
  end

  // run time guard
  initial begin
    #4ms;
    $display("[aabb_all_pairs_contact_engine] ERROR");
    $finish;
  end

endmodule
